FILE: sv/marker_frame_receiver_crc16_unit_assert.svh
// Assertion macros shared by the framed receiver modules.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef MARKER_FRAME_RECEIVER_CRC16_UNIT_ASSERT_SVH
`define MARKER_FRAME_RECEIVER_CRC16_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define MFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("mfr assertion failed");
// Checked property that also holds during reset.
`define MFR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("mfr assertion failed");
`else
`define MFR_ASSERT(lbl, clk, rst_n, prop)
`define MFR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/mfr_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the framed receiver.
// No dependencies; imported by the top level, the controller and the datapath.
package mfr_pkg;

	localparam int unsigned MaxLenDef = 32;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned LenW      = 5;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	localparam logic [ByteW-1:0] StartMarkerRst = 8'h02;
	localparam logic [ByteW-1:0] EndMarkerRst   = 8'h03;

	typedef enum logic [0:0] {
		CFG_START_MARKER = 1'b0,
		CFG_END_MARKER   = 1'b1
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cnt_clr;
		logic store;
		logic crc_start;
		logic crc_issue;
		logic emit_start;
		logic emit_issue;
		logic emit_load;
		logic emit_empty;
	} mfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_start;
		logic is_end;
		logic len_ok;
		logic issue_done;
		logic crc_match;
		logic plen_zero;
		logic emit_done;
		logic out_free;
	} mfr_sts_t;

	// One byte through the reflected CRC-16/MODBUS register, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [ByteW-1:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/marker_frame_receiver_crc16_unit.sv
// Top level of the marker-framed serial receiver with CRC-16/MODBUS check.
// Depends on mfr_pkg, mfr_ctrl, mfr_datapath and mfr_ram.
//
// Usage: received bytes arrive one transfer at a time on rx_byte (in_valid /
// in_ready). A start-marker byte opens a frame and empties the buffer; other
// bytes inside a frame are stored until MAX_LEN are held. An end-marker byte
// closes the frame, and a frame of 2 to MAX_LEN-1 bytes is then checked: its
// last two bytes, low byte first, must match CRC-16/MODBUS over the payload.
// On a match the payload leaves as one output transfer per byte, with is_last
// on the final one; a frame of only the two CRC bytes yields one transfer with
// empty_frame set. The two marker values are written through the cfg port,
// which always accepts, and must only be changed while the block is idle.
// Sequence: an end marker that triggers a check first sweeps the single read
// port of the frame buffer once for the CRC, then drains the payload with one
// buffer read per payload byte, each followed by a load of the output register.
// in_ready stays low from the end marker until the last payload byte sits in
// the output register, so the next byte can be taken while that result still
// waits. A stalled receiver simply holds the drain. Reset clears the markers
// to their defaults, closes any frame and drops a pending result; the buffer
// itself needs no clearing.
module marker_frame_receiver_crc16_unit import mfr_pkg::*; #(
	parameter int unsigned MAX_LEN = MaxLenDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] rx_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ByteW-1:0] payload_byte,
	output logic             is_last,
	output logic [LenW-1:0]  payload_length,
	output logic             empty_frame,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [ByteW-1:0] cfg_data
);

	mfr_cmd_t cmd;
	mfr_sts_t sts;

	// Register writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	mfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mfr_datapath #(
		.MaxLen(MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.payload_byte  (payload_byte),
		.is_last       (is_last),
		.payload_length(payload_length),
		.empty_frame   (empty_frame)
	);

endmodule

FILE: sv/mfr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mfr_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 32,
	localparam int unsigned AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/mfr_datapath.sv
// Datapath of the framed receiver: marker registers, byte count, frame buffer,
// CRC register and the output register. Depends on mfr_pkg and mfr_ram.
`include "marker_frame_receiver_crc16_unit_assert.svh"
module mfr_datapath import mfr_pkg::*; #(
	parameter int unsigned MaxLen = MaxLenDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  cfg_idx_t         cfg_index,
	input  logic [ByteW-1:0] cfg_data,
	input  logic [ByteW-1:0] rx_byte,
	input  logic             out_ready,
	input  mfr_cmd_t         cmd,
	output mfr_sts_t         sts,
	output logic             out_valid,
	output logic [ByteW-1:0] payload_byte,
	output logic             is_last,
	output logic [LenW-1:0]  payload_length,
	output logic             empty_frame
);

	localparam int unsigned CntW = $clog2(MaxLen + 1);
	localparam int unsigned AddrW = $clog2(MaxLen);

	logic [ByteW-1:0] start_q, end_q;
	logic [CntW-1:0]  count_q, idx_q, idx_s1, plen;
	logic             chk_pend_s1;
	logic [15:0]      crc_q;
	logic             match_q;
	logic             out_valid_q;
	logic             ram_we;
	logic [ByteW-1:0] ram_rdata;

	assign plen   = count_q - CntW'(2);
	assign ram_we = cmd.store && (count_q < CntW'(MaxLen));

	mfr_ram #(
		.Width(ByteW),
		.Depth(MaxLen)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AddrW-1:0]),
		.wdata(rx_byte),
		.re   (cmd.crc_issue || cmd.emit_issue),
		.raddr(idx_q[AddrW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= StartMarkerRst;
			end_q   <= EndMarkerRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_MARKER: start_q <= cfg_data;
				CFG_END_MARKER:   end_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			chk_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CntW'(1);
			end
			if (cmd.crc_start || cmd.emit_start) begin
				idx_q <= '0;
			end else if (cmd.crc_issue || cmd.emit_issue) begin
				idx_q <= idx_q + CntW'(1);
			end
			chk_pend_s1 <= cmd.crc_issue;
			if (cmd.emit_load || cmd.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Bytes below the payload length feed the CRC; the two after it are compared.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.crc_start) begin
			crc_q   <= CrcInit;
			match_q <= 1'b1;
		end else if (chk_pend_s1) begin
			if (idx_s1 < plen) begin
				crc_q <= crc16_byte(crc_q, ram_rdata);
			end else if (idx_s1 == plen) begin
				if (ram_rdata != crc_q[7:0]) begin
					match_q <= 1'b0;
				end
			end else if (ram_rdata != crc_q[15:8]) begin
				match_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			payload_byte   <= '0;
			is_last        <= 1'b1;
			payload_length <= '0;
			empty_frame    <= 1'b1;
		end else if (cmd.emit_load) begin
			payload_byte   <= ram_rdata;
			is_last        <= (idx_q == plen);
			payload_length <= LenW'(plen);
			empty_frame    <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.is_start   = (rx_byte == start_q);
		sts.is_end     = (rx_byte == end_q);
		sts.len_ok     = (count_q >= CntW'(2)) && (count_q < CntW'(MaxLen));
		sts.issue_done = (idx_q == count_q);
		sts.crc_match  = match_q;
		sts.plen_zero  = (count_q == CntW'(2));
		sts.emit_done  = (idx_q == plen);
		sts.out_free   = !out_valid_q || out_ready;
	end

	`MFR_ASSERT(a_load_into_free_reg, clk, arst_n, (cmd.emit_load || cmd.emit_empty) |-> (!out_valid_q || out_ready))
	`MFR_ASSERT(a_count_in_range, clk, arst_n, count_q <= CntW'(MaxLen))
	`MFR_ASSERT(a_empty_result_shape, clk, arst_n, (out_valid_q && empty_frame) |-> (is_last && payload_length == '0))

endmodule

FILE: sv/mfr_ctrl.sv
// Controller of the framed receiver: frame tracking, CRC sweep and drain sequencing.
// Depends on mfr_pkg; drives the datapath by mfr_cmd_t and reads mfr_sts_t.
`include "marker_frame_receiver_crc16_unit_assert.svh"
module mfr_ctrl import mfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mfr_sts_t sts,
	output mfr_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DECIDE,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_EMPTY
	} state_t;

	state_t state_q;
	logic   in_frame_q;
	logic   take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (sts.is_start) begin
						cmd.cnt_clr = 1'b1;
					end else if (sts.is_end) begin
						cmd.crc_start = in_frame_q && sts.len_ok;
					end else begin
						cmd.store = in_frame_q;
					end
				end
			end
			ST_CHECK:      cmd.crc_issue  = !sts.issue_done;
			ST_DECIDE:     cmd.emit_start = sts.crc_match && !sts.plen_zero;
			ST_EMIT_RD:    cmd.emit_issue = sts.out_free;
			ST_EMIT_LD:    cmd.emit_load  = 1'b1;
			ST_EMIT_EMPTY: cmd.emit_empty = sts.out_free;
			default:       ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (sts.is_start) begin
							in_frame_q <= 1'b1;
						end else if (sts.is_end && in_frame_q) begin
							in_frame_q <= 1'b0;
							if (sts.len_ok) begin
								state_q <= ST_CHECK;
							end
						end
					end
				end
				ST_CHECK: begin
					if (sts.issue_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!sts.crc_match) begin
						state_q <= ST_IDLE;
					end else if (sts.plen_zero) begin
						state_q <= ST_EMIT_EMPTY;
					end else begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					if (sts.out_free) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD:    state_q <= sts.emit_done ? ST_IDLE : ST_EMIT_RD;
				ST_EMIT_EMPTY: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:       state_q <= ST_IDLE;
			endcase
		end
	end

	`MFR_ASSERT(a_close_starts_check, clk, arst_n, (take && !sts.is_start && sts.is_end && in_frame_q && sts.len_ok) |=> (state_q == ST_CHECK))
	`MFR_ASSERT(a_decide_after_sweep, clk, arst_n, (state_q == ST_DECIDE) |-> ($past(state_q) == ST_CHECK && $past(sts.issue_done)))
	`MFR_ASSERT(a_load_after_free, clk, arst_n, (state_q == ST_EMIT_LD) |-> $past(sts.out_free))

endmodule

FILE: test/testbench.sv
// Self-checking testbench for marker_frame_receiver_crc16_unit: framed bytes in, checked payload out.
// Depends on mfr_pkg and the RTL of the block; a small scoreboard class tracks frames and CRCs.
module testbench;
	import mfr_pkg::*;

	// The buffer depth used by the instance below and by the frame tracker.
	localparam int FrameMax = MaxLenDef;
	// Cycles to let pass once nothing is outstanding: a rejected frame still occupies the
	// block for up to one sweep of its buffer after the end marker is taken.
	localparam int SettleCycles = 2 * FrameMax + 8;
	// Generous bound on the whole run, far above a slow but correct run.
	localparam int CycleLimit = 400000;

	typedef logic [ByteW-1:0] byte_q_t[$];

	// One payload transfer as the block presents it.
	typedef struct {
		logic [ByteW-1:0] payload_byte;
		logic             is_last;
		logic [LenW-1:0]  payload_length;
		logic             empty_frame;
	} payload_result_t;

	// Frame tracker: follows the marker settings and the open frame, works out which payload
	// transfers each received byte releases, and checks the transfers the block emits.
	class frame_tracker;
		logic [ByteW-1:0] start_marker;
		logic [ByteW-1:0] end_marker;
		byte_q_t          frame_bytes;
		bit               frame_open;
		payload_result_t  pending[$];
		int               failures;
		int               compared;
		int               frames_passed;

		function new();
			start_marker  = StartMarkerRst;
			end_marker    = EndMarkerRst;
			frame_open    = 1'b0;
			failures      = 0;
			compared      = 0;
			frames_passed = 0;
		endfunction

		// Reflected CRC-16/MODBUS over the first n bytes of data.
		static function logic [15:0] modbus_crc(byte_q_t data, int n);
			logic [15:0] r;
			logic        lsb;
			r = 16'hFFFF;
			for (int i = 0; i < n; i++) begin
				r = r ^ {8'h00, data[i]};
				for (int k = 0; k < 8; k++) begin
					lsb = r[0];
					r = {1'b0, r[15:1]};
					if (lsb)
						r = r ^ 16'hA001;
				end
			end
			return r;
		endfunction

		function void set_marker(cfg_idx_t idx, logic [ByteW-1:0] value);
			if (idx == CFG_START_MARKER)
				start_marker = value;
			else
				end_marker = value;
		endfunction

		// Called for every byte the block accepts.
		function void take_rx_byte(logic [ByteW-1:0] b);
			int          n;
			logic [15:0] crc;
			// The start marker is tested first, so equal markers only ever open frames.
			if (b == start_marker) begin
				frame_open = 1'b1;
				frame_bytes.delete();
			end else if (b == end_marker) begin
				if (frame_open) begin
					frame_open = 1'b0;
					n = frame_bytes.size() - 2;
					// Too short or full frames are closed without any check.
					if (n >= 0 && n + 2 < FrameMax) begin
						crc = modbus_crc(frame_bytes, n);
						if (frame_bytes[n] == crc[7:0] && frame_bytes[n + 1] == crc[15:8]) begin
							frames_passed++;
							if (n == 0)
								pending.push_back('{8'h00, 1'b1, '0, 1'b1});
							else
								for (int i = 0; i < n; i++)
									pending.push_back('{frame_bytes[i], i == n - 1,
										LenW'(n), 1'b0});
						end
					end
				end
			end else if (frame_open && frame_bytes.size() < FrameMax) begin
				frame_bytes.push_back(b);
			end
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		// Called for every payload transfer the block completes.
		function void check_result(payload_result_t got);
			payload_result_t want;
			if (pending.size() == 0) begin
				note_failure($sformatf("unexpected payload transfer: byte %02h last %0b len %0d empty %0b",
					got.payload_byte, got.is_last, got.payload_length, got.empty_frame));
			end else begin
				want = pending.pop_front();
				compared++;
				// The byte of an empty frame carries no meaning, so it is left unchecked.
				if (got.is_last !== want.is_last || got.payload_length !== want.payload_length ||
						got.empty_frame !== want.empty_frame ||
						(!want.empty_frame && got.payload_byte !== want.payload_byte))
					note_failure($sformatf({"payload transfer %0d mismatch: expected byte %02h ",
						"last %0b len %0d empty %0b, got byte %02h last %0b len %0d empty %0b"},
						compared, want.payload_byte, want.is_last, want.payload_length,
						want.empty_frame, got.payload_byte, got.is_last, got.payload_length,
						got.empty_frame));
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [ByteW-1:0] rx_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ByteW-1:0] payload_byte;
	logic             is_last;
	logic [LenW-1:0]  payload_length;
	logic             empty_frame;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	cfg_idx_t         cfg_index = CFG_START_MARKER;
	logic [ByteW-1:0] cfg_data = '0;

	frame_tracker tracker;
	bit           idling = 1'b1;
	int           rx_sent = 0;
	int           cycle_count = 0;
	int           stall_left = 0;

	marker_frame_receiver_crc16_unit #(
		.MAX_LEN(FrameMax)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.is_last       (is_last),
		.payload_length(payload_length),
		.empty_frame   (empty_frame),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// A 4-unit clock: rising edges at 2, 6, 10 and so on.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog. A hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("marker_frame_receiver_crc16_unit test failed");
			$finish;
		end
	end

	// Receiver side. out_ready changes only at the falling edge; while idling is enabled it
	// drops in random bursts, otherwise it stays high.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (idling && arst_n && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Every completed output transfer is compared at the rising edge that completes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(payload_result_t'{payload_byte, is_last, payload_length,
				empty_frame});
	end

	function automatic bit is_marker(logic [ByteW-1:0] b);
		return b == tracker.start_marker || b == tracker.end_marker;
	endfunction

	// A random byte that the block will store rather than treat as a marker.
	function automatic logic [ByteW-1:0] data_byte();
		logic [ByteW-1:0] b;
		do
			b = ByteW'($urandom_range(0, 255));
		while (is_marker(b));
		return b;
	endfunction

	// Presents one byte and holds it until the block takes it. The byte is changed at the
	// falling edge, and a random sender gap may come first while idling is on.
	// Stray random bytes sent between frames are not counted towards the phase budget.
	task automatic send_rx(input logic [ByteW-1:0] b, input bit counted = 1'b1);
		@(negedge clk);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_rx_byte(b);
		if (counted)
			rx_sent++;
	endtask

	// Sends a whole frame: start marker, payload, CRC low then high, end marker. A corrupted
	// frame has one CRC byte altered so that the check fails.
	task automatic send_frame(input byte_q_t payload, input bit corrupt);
		logic [15:0]      crc;
		logic [ByteW-1:0] flip;
		crc = frame_tracker::modbus_crc(payload, payload.size());
		if (corrupt) begin
			flip = ByteW'($urandom_range(1, 255));
			if ($urandom_range(0, 1))
				crc[7:0] = crc[7:0] ^ flip;
			else
				crc[15:8] = crc[15:8] ^ flip;
		end
		send_rx(tracker.start_marker);
		foreach (payload[i])
			send_rx(payload[i]);
		send_rx(crc[7:0]);
		send_rx(crc[15:8]);
		send_rx(tracker.end_marker);
	endtask

	// A frame with random payload. For a good frame the payload is drawn again a few times if
	// a CRC byte happens to equal a marker, as that would break the frame apart.
	task automatic send_random_frame(input int plen, input bit corrupt);
		byte_q_t     q;
		logic [15:0] crc;
		int          tries;
		tries = 0;
		do begin
			q.delete();
			repeat (plen) q.push_back(data_byte());
			crc = frame_tracker::modbus_crc(q, plen);
			tries++;
		end while (!corrupt && tries < 8 && (is_marker(crc[7:0]) || is_marker(crc[15:8])));
		send_frame(q, corrupt);
	endtask

	task automatic park_rx();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits until every expected transfer has arrived, then lets the block finish any check
	// of a frame that produces nothing.
	task automatic wait_idle();
		park_rx();
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_marker(input cfg_idx_t idx, input logic [ByteW-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_marker(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Random traffic: mostly well-formed frames with random content, mixed with corrupted,
	// overfull, restarted and too short frames, and stray bytes outside any frame.
	task automatic run_traffic(input int budget, input bit vary_idle);
		int target;
		int r;
		int plen;
		target = rx_sent + budget;
		while (rx_sent < target) begin
			if (vary_idle && $urandom_range(0, 9) == 0)
				idling = !idling;
			r = $urandom_range(0, 99);
			if (r < 60) begin
				// Mostly short payloads; now and then the longest one and one that just
				// fills the buffer, which must be rejected.
				plen = $urandom_range(0, 9);
				if (plen < 6)
					plen = $urandom_range(0, 6);
				else if (plen < 9)
					plen = $urandom_range(7, FrameMax - 4);
				else
					plen = $urandom_range(FrameMax - 3, FrameMax - 2);
				send_random_frame(plen, 1'b0);
			end else if (r < 70) begin
				send_random_frame($urandom_range(0, 8), 1'b1);
			end else if (r < 76) begin
				// Overfull frame: the surplus bytes are dropped and the frame rejected.
				send_rx(tracker.start_marker);
				repeat ($urandom_range(FrameMax, FrameMax + 4)) send_rx(data_byte());
				send_rx(tracker.end_marker);
			end else if (r < 82) begin
				// A second start marker throws away what was gathered so far.
				send_rx(tracker.start_marker);
				repeat ($urandom_range(1, 5)) send_rx(data_byte());
				send_random_frame($urandom_range(0, 6), 1'b0);
			end else if (r < 88) begin
				send_rx(tracker.start_marker);
				if ($urandom_range(0, 1))
					send_rx(data_byte());
				send_rx(tracker.end_marker);
			end else begin
				repeat ($urandom_range(1, 4)) send_rx(ByteW'($urandom_range(0, 255)), 1'b0);
			end
		end
	endtask

	initial begin
		byte_q_t          fixed;
		logic [ByteW-1:0] new_start;
		logic [ByteW-1:0] new_end;

		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the markers at their reset values. An end marker and an ordinary
		// byte outside any frame must both be ignored.
		send_rx(tracker.end_marker);
		send_rx(8'h55);
		// A frame of only the two CRC bytes gives the single empty-frame transfer.
		fixed.delete();
		send_frame(fixed, 1'b0);
		// Frames holding no byte or one byte are too short to carry a CRC.
		send_rx(tracker.start_marker);
		send_rx(tracker.end_marker);
		send_rx(tracker.start_marker);
		send_rx(8'h00);
		send_rx(tracker.end_marker);
		// Single-byte payloads 00 and 80, one good and one with a broken CRC.
		fixed = {8'h00};
		send_frame(fixed, 1'b0);
		fixed = {8'h80};
		send_frame(fixed, 1'b1);
		// A start marker inside an open frame restarts it.
		send_rx(tracker.start_marker);
		send_rx(8'h11);
		fixed = {8'hFF};
		send_frame(fixed, 1'b0);
		wait_idle();

		run_traffic(110, 1'b1);

		// Extreme marker values in both orders.
		wait_idle();
		write_marker(CFG_START_MARKER, 8'h00);
		write_marker(CFG_END_MARKER, 8'hFF);
		run_traffic(90, 1'b1);

		wait_idle();
		write_marker(CFG_START_MARKER, 8'hFF);
		write_marker(CFG_END_MARKER, 8'h00);
		run_traffic(70, 1'b1);

		// Equal markers: every marker byte opens or restarts a frame, none closes one.
		wait_idle();
		write_marker(CFG_START_MARKER, 8'h7E);
		write_marker(CFG_END_MARKER, 8'h7E);
		send_rx(8'h7E);
		send_rx(data_byte());
		send_rx(data_byte());
		send_rx(8'h7E);
		send_rx(data_byte());
		send_rx(8'h7E);
		run_traffic(30, 1'b1);

		// Last part: random distinct markers and no idling on either side.
		wait_idle();
		idling = 1'b0;
		new_start = ByteW'($urandom_range(0, 255));
		do
			new_end = ByteW'($urandom_range(0, 255));
		while (new_end == new_start);
		write_marker(CFG_START_MARKER, new_start);
		write_marker(CFG_END_MARKER, new_end);
		run_traffic(80, 1'b0);
		wait_idle();

		$display("Sent %0d counted bytes under five marker settings, equal and extreme ones included.",
			rx_sent);
		$display("%0d frames passed their CRC check, %0d payload transfers compared, %0d mismatches.",
			tracker.frames_passed, tracker.compared, tracker.failures);
		if (tracker.failures == 0 && tracker.pending.size() == 0)
			$display("marker_frame_receiver_crc16_unit test passed");
		else
			$display("marker_frame_receiver_crc16_unit test failed");
		$finish;
	end

endmodule
